// ----- hdl/ufil_pkg.sv -----
// shared types and constants for the utf-8 sequence filter
package ufil_pkg;

	// byte class boundaries
	localparam logic [7:0] ASCII_MAX  = 8'h7f;
	localparam logic [7:0] LEAD2_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX  = 8'hdf;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [7:0] LEAD3_MAX  = 8'hef;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX  = 8'hf4;
	localparam logic [7:0] TRAIL_MIN  = 8'h80;
	localparam logic [7:0] TRAIL_MAX  = 8'hbf;

	// second-byte limits after special leads
	localparam logic [7:0] LEAD_E0    = 8'he0;
	localparam logic [7:0] E0_SECOND_MIN = 8'ha0;
	localparam logic [7:0] LEAD_F0    = 8'hf0;
	localparam logic [7:0] F0_SECOND_MIN = 8'h90;
	localparam logic [7:0] LEAD_F4    = 8'hf4;
	localparam logic [7:0] F4_SECOND_MAX = 8'h8f;

	// group lengths
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// one queued command: up to four result items
	typedef struct packed {
		logic [3:0][7:0] data;     // data[0] goes out first
		logic [1:0]      cnt_m1;   // number of items minus one
		logic            present;  // 0 for a bare end-of-string marker
		logic            last;     // final command of the string
	} cmd_t;

endpackage

// ----- hdl/ufil_front.sv -----
// front end: byte classification, group tracking and command generation
module ufil_front import ufil_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       enq,
	output cmd_t       cmd
);

	logic [7:0] lead_q;
	logic [7:0] second_q;
	logic [7:0] third_q;
	logic [2:0] len_q;
	logic [2:0] count_q;
	logic       ok_q;

	logic [7:0] lead_n;
	logic [2:0] len_n;
	logic [2:0] count_n;
	logic       ok_n;
	logic       wr_second;
	logic       wr_third;
	logic       emit;
	logic [1:0] emit_m1;
	logic [3:0][7:0] emit_data;
	logic [2:0] count_inc;
	logic       trail_ok;

	assign trail_ok  = (in_byte >= TRAIL_MIN) && (in_byte <= TRAIL_MAX);
	assign count_inc = count_q + 3'd1;

	always_comb begin
		lead_n    = lead_q;
		len_n     = len_q;
		count_n   = count_q;
		ok_n      = ok_q;
		wr_second = 1'b0;
		wr_third  = 1'b0;
		emit      = 1'b0;
		emit_m1   = 2'd0;
		emit_data = '0;
		if (len_q == LEN_NONE) begin
			emit_data[0] = in_byte;
			if (in_byte <= ASCII_MAX) begin
				emit = 1'b1;
			end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
				lead_n = in_byte; len_n = LEN_TWO; count_n = 3'd1; ok_n = 1'b1;
			end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
				lead_n = in_byte; len_n = LEN_THREE; count_n = 3'd1; ok_n = 1'b1;
			end else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX) begin
				lead_n = in_byte; len_n = LEN_FOUR; count_n = 3'd1; ok_n = 1'b1;
			end
		end else begin
			if (!trail_ok)
				ok_n = 1'b0;
			if (count_q == 3'd1) begin
				if (lead_q == LEAD_E0 && in_byte < E0_SECOND_MIN) ok_n = 1'b0;
				if (lead_q == LEAD_F0 && in_byte < F0_SECOND_MIN) ok_n = 1'b0;
				if (lead_q == LEAD_F4 && in_byte > F4_SECOND_MAX) ok_n = 1'b0;
			end
			// keep middle bytes until the group completes
			wr_second = (count_q == 3'd1) && (count_inc < len_q);
			wr_third  = (count_q == 3'd2) && (count_inc < len_q);
			count_n   = count_inc;
			emit_data[0] = lead_q;
			emit_data[1] = (len_q == LEN_TWO) ? in_byte : second_q;
			emit_data[2] = (len_q == LEN_THREE) ? in_byte : third_q;
			emit_data[3] = in_byte;
			emit_m1      = 2'(len_q - 3'd1);
			if (count_inc >= len_q) begin
				emit    = ok_n;
				lead_n  = '0;
				len_n   = LEN_NONE;
				count_n = 3'd0;
				ok_n    = 1'b1;
			end
		end
		// end of string always closes any open group
		if (end_of_string) begin
			lead_n  = '0;
			len_n   = LEN_NONE;
			count_n = 3'd0;
			ok_n    = 1'b1;
		end
	end

	always_comb begin
		enq         = accept && (emit || end_of_string);
		cmd.last    = end_of_string;
		cmd.present = emit;
		cmd.cnt_m1  = emit ? emit_m1 : 2'd0;
		cmd.data    = emit ? emit_data : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			len_q   <= LEN_NONE;
			count_q <= 3'd0;
			ok_q    <= 1'b1;
		end else if (accept) begin
			lead_q  <= lead_n;
			len_q   <= len_n;
			count_q <= count_n;
			ok_q    <= ok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_second)
			second_q <= in_byte;
		if (accept && wr_third)
			third_q <= in_byte;
	end

endmodule

// ----- hdl/ufil_cmdq.sv -----
// small command queue between front end and back end
module ufil_cmdq import ufil_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic enq,
	input  cmd_t enq_cmd,
	output logic full,
	input  logic deq,
	output cmd_t head,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (deq)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (enq && !deq)
				count_q <= count_q + 1'b1;
			else if (deq && !enq)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (enq)
			slot_q[wr_ptr_q] <= enq_cmd;
	end

endmodule

// ----- hdl/ufil_back.sv -----
// back end: walks each queued command out one result item at a time
module ufil_back import ufil_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	input  logic       pop,
	output logic       deq,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       last
);

	logic [1:0] pos_q;
	logic       at_end;
	logic       take;

	assign at_end       = (pos_q == head.cnt_m1);
	assign take         = pop && !empty;
	assign deq          = take && at_end;
	assign out_byte     = head.data[pos_q];
	assign byte_present = head.present;
	assign last         = head.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (take) begin
			pos_q <= at_end ? 2'd0 : pos_q + 2'd1;
		end
	end

endmodule

// ----- hdl/utf8_invalid_sequence_filter.sv -----
// top level of the utf-8 sequence filter
//
//  channel   handshake           payload
//  -------   -----------------   ----------------------------------
//  input     push / full         in_byte, end_of_string
//  result    empty / pop         out_byte, byte_present, last
//
// one input item per cycle is taken while the command queue has room;
// a completed group of n bytes goes out as n result items, one per cycle
// while pop is held, so the result side sets the pace at one item per cycle.
// the first result item of a command is on the ports once it is at the queue head.
// reset clears the open group and empties the queue; no clearing pass.
// a four-byte group leaves the results up to three items behind the input;
// the default depth of five absorbs that, so full rises only when
// QUEUE_DEPTH commands wait behind a stalled pop;
// results stay on the ports unchanged until popped.
module utf8_invalid_sequence_filter import ufil_pkg::*; #(
	parameter int QUEUE_DEPTH = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	// input item side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	// result item side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       last
);

	logic accept;
	logic enq;
	cmd_t enq_cmd;
	logic deq;
	cmd_t head;

	// an item is taken whenever there is room for the command it may make
	assign accept = push && !full;

	// front end: tracks the open group and decides what a byte produces
	ufil_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.enq           (enq),
		.cmd           (enq_cmd)
	);

	// decoupling queue of whole-group commands
	ufil_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_cmd (enq_cmd),
		.full    (full),
		.deq     (deq),
		.head    (head),
		.empty   (empty)
	);

	// back end: serializes the head command onto the result ports
	ufil_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.deq          (deq),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.last         (last)
	);

endmodule

// ----- dv/tb_utf8_invalid_sequence_filter.sv -----
// self-checking testbench for the utf-8 sequence filter
`timescale 1ns / 1ps

module tb_utf8_invalid_sequence_filter;
	import ufil_pkg::*;

	// how a stimulus row is checked
	typedef enum logic [1:0] {
		BY_MODEL,    // expectation comes from the filter model below
		NO_RESULT,   // typed in: the item causes nothing
		ONE_RESULT   // typed in: the item causes exactly the row's result
	} check_t;

	// one result item as seen on the result ports
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} result_t;

	// one input item plus how to check it
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		logic       hold;   // wait for every pending result before offering it
		check_t     chk;
		result_t    want;   // typed-in result for ONE_RESULT rows
	} stim_t;

	localparam result_t NO_DATA      = '0;
	localparam int      RANDOM_ITEMS = 500;
	localparam int      DRAIN_CYCLES = 16;        // queue depth plus slack
	localparam int      TIMEOUT_NS   = 10_000_000;

	// directed part: byte extremes, every group length, every second-byte limit,
	// the surrogate range, a group cut off by end of string, and bare markers
	localparam stim_t DIRECTED [0:25] = '{
		// smallest ascii byte passes at once
		'{8'h00, 1'b0, 1'b0, ONE_RESULT, '{8'h00, 1'b1, 1'b0}},
		// largest ascii byte closing a string carries last
		'{8'h7f, 1'b1, 1'b0, ONE_RESULT, '{8'h7f, 1'b1, 1'b1}},
		// stray trailing byte outside a group is dropped
		'{8'h80, 1'b0, 1'b0, NO_RESULT,  NO_DATA},
		// dropped byte ends the string: only the bare marker comes out
		'{8'hff, 1'b1, 1'b0, ONE_RESULT, '{8'h00, 1'b0, 1'b1}},
		// two-byte groups at the low and high ends
		'{8'hc2, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'hdf, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'hbf, 1'b1, 1'b0, BY_MODEL,   NO_DATA},
		// e0 with second byte just under its limit: group swallowed, marker
		'{8'he0, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h9f, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b1, 1'b0, BY_MODEL,   NO_DATA},
		// surrogate range after ed is let through
		'{8'hed, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'ha0, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'hbf, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		// f4 with second byte just over its limit
		'{8'hf4, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h90, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		// f0 with second byte right at its limit, four bytes out with last
		'{8'hf0, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h90, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'hbf, 1'b1, 1'b0, BY_MODEL,   NO_DATA},
		// group cut off by end of string
		'{8'he1, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h80, 1'b1, 1'b0, BY_MODEL,   NO_DATA},
		// ascii where a trailing byte belongs spoils the group
		'{8'hc2, 1'b0, 1'b0, BY_MODEL,   NO_DATA},
		'{8'h41, 1'b1, 1'b0, BY_MODEL,   NO_DATA}
	};

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       end_of_string;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       last;

	// filter model state: the group being collected
	logic [7:0] open_lead;
	logic [7:0] open_mid [2];
	logic [2:0] open_len;
	logic [2:0] open_cnt;
	logic       open_ok;

	stim_t      stim_q [$];       // input items not yet accepted
	result_t    filtered_q [$];   // result items still owed by the block
	logic [7:0] text_q [$];       // bytes of the string being built

	stim_t      item;
	result_t    want;
	int         tx_gap;
	int         rx_gap;
	bit         calm;             // stretch with no idling on either side
	int         errors;
	int         random_items;
	int         items_sent;
	int         strings_sent;
	int         results_seen;
	int         markers_seen;
	bit         first_string;

	utf8_invalid_sequence_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.byte_present  (byte_present),
		.last          (last)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// forget any open group
	task automatic drop_group();
		open_lead = 8'h00;
		open_len  = LEN_NONE;
		open_cnt  = 3'd0;
		open_ok   = 1'b1;
	endtask

	// filter model: advance the group state by one byte and, if record is set,
	// queue the result items the byte causes
	task automatic filter_byte(input logic [7:0] b, input logic eos, input bit record);
		result_t    res [4];
		int         n;
		int         i;
		logic [2:0] len_new;
		n = 0;
		len_new = LEN_NONE;
		if (open_len == LEN_NONE) begin
			// outside a group: ascii passes, leads open a group, the rest is dropped
			if (b <= ASCII_MAX) begin
				res[n] = '{b, 1'b1, 1'b0};
				n++;
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				len_new = LEN_TWO;
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				len_new = LEN_THREE;
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				len_new = LEN_FOUR;
			end
			if (len_new != LEN_NONE) begin
				open_lead = b;
				open_len  = len_new;
				open_cnt  = 3'd1;
				open_ok   = 1'b1;
			end
		end else begin
			// inside a group every byte is consumed, good or bad
			if (b < TRAIL_MIN || b > TRAIL_MAX)
				open_ok = 1'b0;
			if (open_cnt == 3'd1) begin
				if (open_lead == LEAD_E0 && b < E0_SECOND_MIN) open_ok = 1'b0;
				if (open_lead == LEAD_F0 && b < F0_SECOND_MIN) open_ok = 1'b0;
				if (open_lead == LEAD_F4 && b > F4_SECOND_MAX) open_ok = 1'b0;
			end
			if (open_cnt + 1 < open_len)
				open_mid[1'(open_cnt - 3'd1)] = b;
			open_cnt = open_cnt + 3'd1;
			if (open_cnt >= open_len) begin
				if (open_ok) begin
					res[n] = '{open_lead, 1'b1, 1'b0};
					n++;
					for (i = 0; i + 2 < open_len; i++) begin
						res[n] = '{open_mid[i], 1'b1, 1'b0};
						n++;
					end
					res[n] = '{b, 1'b1, 1'b0};
					n++;
				end
				drop_group();
			end
		end
		if (eos) begin
			// end of string: partial group gone, last flag or bare marker
			drop_group();
			if (n == 0) begin
				res[0] = '{8'h00, 1'b0, 1'b1};
				n = 1;
			end else begin
				res[n - 1].last = 1'b1;
			end
		end
		if (record)
			for (i = 0; i < n; i++)
				filtered_q.push_back(res[i]);
	endtask

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// append one group of len bytes to the string; spoil puts a random byte
	// somewhere after the lead, cut keeps only a prefix of the group
	task automatic add_group(input int len, input bit spoil, input bit cut);
		logic [7:0] g [4];
		int         keep;
		int         i;
		case (len)
			2: begin
				g[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
			end
			3: begin
				// lean on e0, whose second byte has a limit, and on ed
				if ($urandom_range(0, 3) == 0)
					g[0] = $urandom_range(0, 1) ? LEAD_E0 : 8'hed;
				else
					g[0] = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
			end
			default: begin
				g[0] = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
			end
		endcase
		for (i = 1; i < len; i++)
			g[i] = 8'($urandom_range(TRAIL_MIN, TRAIL_MAX));
		// keep the second byte inside the narrower window of some leads
		if (g[0] == LEAD_E0) g[1] = 8'($urandom_range(E0_SECOND_MIN, TRAIL_MAX));
		if (g[0] == LEAD_F0) g[1] = 8'($urandom_range(F0_SECOND_MIN, TRAIL_MAX));
		if (g[0] == LEAD_F4) g[1] = 8'($urandom_range(TRAIL_MIN, F4_SECOND_MAX));
		// a trailing-range byte here tests the second-byte limits
		if (spoil)
			g[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 1) ?
				$urandom_range(0, 255) : $urandom_range(TRAIL_MIN, TRAIL_MAX));
		keep = cut ? $urandom_range(1, len - 1) : len;
		for (i = 0; i < keep; i++)
			text_q.push_back(g[i]);
	endtask

	// one random string: mostly well-formed groups and ascii, some broken
	// groups and stray bytes; the last byte carries end of string
	task automatic add_string(input bit hold);
		stim_t s;
		int    parts;
		int    kind;
		int    i;
		parts = $urandom_range(1, 6);
		for (i = 0; i < parts; i++) begin
			kind = $urandom_range(0, 19);
			if (kind <= 6)
				text_q.push_back(8'($urandom_range(0, ASCII_MAX)));
			else if (kind <= 9)
				add_group(2, 1'b0, 1'b0);
			else if (kind <= 12)
				add_group(3, 1'b0, 1'b0);
			else if (kind <= 15)
				add_group(4, 1'b0, 1'b0);
			else if (kind == 16)
				add_group($urandom_range(2, 4), 1'b1, 1'b0);
			else if (kind == 17)
				add_group($urandom_range(2, 4), 1'b0, 1'b1);
			else if (kind == 18)
				text_q.push_back(8'($urandom_range(0, 255)));
			else
				text_q.push_back(8'($urandom_range(0, 1) ?
					$urandom_range(TRAIL_MIN, 8'hc1) : $urandom_range(8'hf5, 8'hff)));
		end
		for (i = 0; i < text_q.size(); i++) begin
			s.data = text_q[i];
			s.eos  = (i == text_q.size() - 1);
			s.hold = hold && (i == 0);
			s.chk  = BY_MODEL;
			s.want = NO_DATA;
			stim_q.push_back(s);
		end
		random_items += text_q.size();
		text_q.delete();
	endtask

	// both handshakes, sampled and driven at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				calm = !calm;

			// result side: compare each accepted result with the oldest one owed
			if (pop && !empty) begin
				results_seen++;
				if (!byte_present)
					markers_seen++;
				if (filtered_q.size() == 0) begin
					$error("result item with nothing owed: out_byte %h byte_present %b last %b",
						out_byte, byte_present, last);
					errors++;
				end else begin
					want = filtered_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						errors++;
					end
					if (byte_present !== want.present) begin
						$error("byte_present: expected %b, got %b", want.present, byte_present);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						errors++;
					end
				end
				rx_gap = pick_gap();
			end else if (rx_gap > 0) begin
				rx_gap--;
			end
			pop <= (rx_gap == 0);

			// input side: an accepted item advances the filter model
			if (push && !full) begin
				item = stim_q.pop_front();
				items_sent++;
				if (item.eos)
					strings_sent++;
				filter_byte(item.data, item.eos, item.chk == BY_MODEL);
				if (item.chk == ONE_RESULT)
					filtered_q.push_back(item.want);
				tx_gap = pick_gap();
			end else if (tx_gap > 0) begin
				tx_gap--;
			end

			// offer the next item unless idling or holding off for a drain
			if (stim_q.size() != 0 && tx_gap == 0 &&
				!(stim_q[0].hold && filtered_q.size() != 0)) begin
				push          <= 1'b1;
				in_byte       <= stim_q[0].data;
				end_of_string <= stim_q[0].eos;
			end else begin
				push          <= 1'b0;
				in_byte       <= 8'($urandom);
				end_of_string <= 1'($urandom);
			end
		end
	end

	// stimulus build, reset, drain and verdict
	initial begin
		int i;
		clk           = 1'b0;
		arst_n        = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		in_byte       = 8'h00;
		end_of_string = 1'b0;
		tx_gap        = 0;
		rx_gap        = 0;
		calm          = 1'b0;
		errors        = 0;
		random_items  = 0;
		items_sent    = 0;
		strings_sent  = 0;
		results_seen  = 0;
		markers_seen  = 0;
		drop_group();

		for (i = 0; i < $size(DIRECTED); i++)
			stim_q.push_back(DIRECTED[i]);
		// the first random string waits until the directed part has drained,
		// later ones do so now and then
		first_string = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			add_string(first_string || $urandom_range(0, 9) == 0);
			first_string = 1'b0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || filtered_q.size() != 0)
			@(posedge clk);
		// catch anything extra still on its way out
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d input items in %0d strings; checked %0d result items, %0d of them bare end markers",
			items_sent, strings_sent, results_seen, markers_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hard stop if the handshakes hang
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d input items and %0d result items outstanding",
			stim_q.size(), filtered_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ufil_pkg.sv
hdl/ufil_front.sv
hdl/ufil_cmdq.sv
hdl/ufil_back.sv
hdl/utf8_invalid_sequence_filter.sv
dv/tb_utf8_invalid_sequence_filter.sv
